### hw/rtl/tpc_pkg.sv
`timescale 1ns / 1ps

package tpc_pkg;

   // channel table size
   localparam int NUM_CHANNELS_DEFAULT = 256;

   // configuration port
   localparam int CSR_INDEX_W = 1;
   localparam int CSR_DATA_W  = 48;
   localparam logic [CSR_INDEX_W-1:0] CSR_SNR_THRESH_SQ   = 1'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_MAX_GAP_SAMPLES = 1'd1;

   // register reset values: threshold is 5.5 squared in Q16.32, gap is about 10 ms
   localparam logic [47:0] SNR_THRESH_SQ_RESET   = 48'd129922760704;
   localparam logic [19:0] MAX_GAP_SAMPLES_RESET = 20'd41;

   // item kinds
   localparam logic REQ_SAMPLE  = 1'b0;
   localparam logic REQ_RESTART = 1'b1;

   typedef struct packed {
      logic               req_type;
      logic [7:0]         channel;
      logic [31:0]        sample_time;
      logic signed [23:0] snr_re;
      logic signed [23:0] snr_im;
      logic [31:0]        chisq_value;
   } req_payload_type;

   typedef struct packed {
      logic [7:0]         event_channel;
      logic [31:0]        event_time;
      logic signed [23:0] event_re;
      logic signed [23:0] event_im;
      logic [31:0]        event_chisq;
   } rsp_payload_type;

   // item after the magnitude stage
   typedef struct packed {
      logic               valid;
      logic               restart;
      logic               above;
      logic [7:0]         channel;
      logic [31:0]        sample_time;
      logic signed [23:0] snr_re;
      logic signed [23:0] snr_im;
      logic [31:0]        chisq_value;
      logic [47:0]        mag_sq;
   } tpc_stage_type;

   // one entry of the per-channel peak table
   typedef struct packed {
      logic [47:0]        peak_mag_sq;
      logic signed [23:0] peak_re;
      logic signed [23:0] peak_im;
      logic [31:0]        peak_chisq;
      logic [31:0]        peak_time;
      logic [31:0]        last_above_time;
   } tpc_entry_type;

endpackage

### hw/rtl/tpc_ram.sv
`timescale 1ns / 1ps

module tpc_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 256,
   localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic              clock,
   input  logic              wr_en,
   input  logic [ADDR_W-1:0] wr_addr,
   input  logic [WIDTH-1:0]  wr_data,
   input  logic              rd_en,
   input  logic [ADDR_W-1:0] rd_addr,
   output logic [WIDTH-1:0]  rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

### hw/rtl/tpc_front.sv
`timescale 1ns / 1ps

module tpc_front (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     advance,
   input  logic                     accept,
   input  tpc_pkg::req_payload_type in_item,
   input  logic [47:0]              snr_thresh_sq,
   output tpc_pkg::tpc_stage_type   stage_out
);

   import tpc_pkg::*;

   logic            s1_valid_ff;
   req_payload_type s1_item_ff;
   logic signed [47:0] re_sq;
   logic signed [47:0] im_sq;
   logic [47:0]        mag_sq;

   // input register
   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else if (advance) begin
         s1_valid_ff <= accept;
      end
      if (advance && accept) begin
         s1_item_ff <= in_item;
      end
   end

   // squared magnitude, exact in 48 bits
   assign re_sq  = s1_item_ff.snr_re * s1_item_ff.snr_re;
   assign im_sq  = s1_item_ff.snr_im * s1_item_ff.snr_im;
   assign mag_sq = $unsigned(re_sq) + $unsigned(im_sq);

   always_comb begin
      stage_out.valid       = s1_valid_ff;
      stage_out.restart     = (s1_item_ff.req_type == REQ_RESTART);
      stage_out.above       = (mag_sq >= snr_thresh_sq);
      stage_out.channel     = s1_item_ff.channel;
      stage_out.sample_time = s1_item_ff.sample_time;
      stage_out.snr_re      = s1_item_ff.snr_re;
      stage_out.snr_im      = s1_item_ff.snr_im;
      stage_out.chisq_value = s1_item_ff.chisq_value;
      stage_out.mag_sq      = mag_sq;
   end

endmodule

### hw/rtl/tpc_cluster.sv
`timescale 1ns / 1ps

module tpc_cluster #(
   parameter int NUM_CHANNELS = tpc_pkg::NUM_CHANNELS_DEFAULT
) (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     advance,
   input  tpc_pkg::tpc_stage_type   stage_in,
   input  logic [19:0]              max_gap_samples,
   output logic                     emit,
   output tpc_pkg::rsp_payload_type event_out
);

   import tpc_pkg::*;

   localparam int IDX_W   = (NUM_CHANNELS > 1) ? $clog2(NUM_CHANNELS) : 1;
   localparam int ENTRY_W = $bits(tpc_entry_type);

   tpc_stage_type     s2_ff;
   logic [NUM_CHANNELS-1:0] pending_ff;
   logic [NUM_CHANNELS-1:0] seen_ff;
   logic              fwd_hit_ff;
   tpc_entry_type     fwd_entry_ff;

   logic [IDX_W-1:0]   rd_idx;
   logic [IDX_W-1:0]   s2_idx;
   logic [ENTRY_W-1:0] rd_data;
   tpc_entry_type      entry;
   tpc_entry_type      wr_entry;
   logic               in_range;
   logic               sample_ok;
   logic               pend;
   logic               seen;
   logic [31:0]        gap_val;
   logic               new_event;
   logic               store;
   logic               wr_en;

   assign rd_idx = IDX_W'(stage_in.channel);
   assign s2_idx = IDX_W'(s2_ff.channel);

   // peak table: read as the item enters, written back as it leaves
   tpc_ram #(
      .WIDTH (ENTRY_W),
      .DEPTH (NUM_CHANNELS)
   ) u_table (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (s2_idx),
      .wr_data (wr_entry),
      .rd_en   (advance),
      .rd_addr (rd_idx),
      .rd_data (rd_data)
   );

   // clustering decision for the item in the second stage
   always_comb begin
      entry     = fwd_hit_ff ? fwd_entry_ff : tpc_entry_type'(rd_data);
      in_range  = (32'(s2_ff.channel) < NUM_CHANNELS);
      sample_ok = s2_ff.valid && !s2_ff.restart && in_range && s2_ff.above;
      pend      = sample_ok && pending_ff[s2_idx];
      seen      = sample_ok && seen_ff[s2_idx];
      gap_val   = s2_ff.sample_time - entry.last_above_time;
      new_event = !seen || (gap_val > 32'(max_gap_samples));
      emit      = sample_ok && new_event && pend;
      store     = new_event || !pend || (s2_ff.mag_sq > entry.peak_mag_sq);
      wr_en     = sample_ok && advance;

      wr_entry = entry;
      if (store) begin
         wr_entry.peak_mag_sq = s2_ff.mag_sq;
         wr_entry.peak_re     = s2_ff.snr_re;
         wr_entry.peak_im     = s2_ff.snr_im;
         wr_entry.peak_chisq  = s2_ff.chisq_value;
         wr_entry.peak_time   = s2_ff.sample_time;
      end
      wr_entry.last_above_time = s2_ff.sample_time;

      event_out.event_channel = s2_ff.channel;
      event_out.event_time    = entry.peak_time;
      event_out.event_re      = entry.peak_re;
      event_out.event_im      = entry.peak_im;
      event_out.event_chisq   = entry.peak_chisq;
   end

   // stage register and forwarding of a write to the entry being read
   always_ff @(posedge clock) begin
      if (reset) begin
         s2_ff.valid <= 1'b0;
         fwd_hit_ff  <= 1'b0;
      end else if (advance) begin
         s2_ff      <= stage_in;
         fwd_hit_ff <= wr_en && stage_in.valid && (s2_idx == rd_idx);
      end
      if (advance) begin
         fwd_entry_ff <= wr_entry;
      end
   end

   // per-channel flags; restart drops every pending peak at once
   always_ff @(posedge clock) begin
      if (reset) begin
         pending_ff <= '0;
         seen_ff    <= '0;
      end else if (advance) begin
         if (s2_ff.valid && s2_ff.restart) begin
            pending_ff <= '0;
         end else if (sample_ok) begin
            pending_ff[s2_idx] <= 1'b1;
            seen_ff[s2_idx]    <= 1'b1;
         end
      end
   end

endmodule

### hw/rtl/per_channel_trigger_peak_clustering.sv
`timescale 1ns / 1ps
// Per-channel threshold trigger with peak clustering. One item is taken per clock;
// a finished peak is registered as its closing sample leaves the second stage.
// Input stalls only while a peak is due and the result register is full and
// stalled. The per-channel peak table is a RAM with one read and one write port:
// each item reads its entry entering the second stage and writes it back on exit,
// and a forwarding register covers an item of the same channel right behind.
// Pending and seen flags are flip-flops, so a segment restart drops all pending
// peaks at once and no clearing pass follows reset. The user writes configuration
// via csr_wr_en, csr_index and csr_wdata only while idle; the block does not check.

module per_channel_trigger_peak_clustering #(
   parameter int NUM_CHANNELS = tpc_pkg::NUM_CHANNELS_DEFAULT
) (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  req_valid,
   output logic                                  req_stall,
   input  tpc_pkg::req_payload_type              req_payload,
   output logic                                  rsp_valid,
   input  logic                                  rsp_stall,
   output tpc_pkg::rsp_payload_type              rsp_payload,
   input  logic                                  csr_wr_en,
   input  logic [tpc_pkg::CSR_INDEX_W-1:0]       csr_index,
   input  logic [tpc_pkg::CSR_DATA_W-1:0]        csr_wdata
);

   import tpc_pkg::*;

   logic [47:0]     snr_thresh_sq_ff;
   logic [19:0]     max_gap_samples_ff;
   logic            rsp_valid_ff;
   rsp_payload_type rsp_payload_ff;

   logic            hold;
   logic            advance;
   logic            accept;
   logic            emit;
   tpc_stage_type   stage;
   rsp_payload_type event_item;

   // pipeline freezes only when a peak is due and the output is blocked
   assign hold      = rsp_valid_ff && rsp_stall && emit;
   assign advance   = !hold;
   assign req_stall = hold;
   assign accept    = req_valid && !hold;

   // configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         snr_thresh_sq_ff   <= SNR_THRESH_SQ_RESET;
         max_gap_samples_ff <= MAX_GAP_SAMPLES_RESET;
      end else if (csr_wr_en) begin
         case (csr_index)
            CSR_SNR_THRESH_SQ: begin
               snr_thresh_sq_ff <= csr_wdata[47:0];
            end
            CSR_MAX_GAP_SAMPLES: begin
               max_gap_samples_ff <= csr_wdata[19:0];
            end
            default: begin
            end
         endcase
      end
   end

   tpc_front u_front (
      .clock         (clock),
      .reset         (reset),
      .advance       (advance),
      .accept        (accept),
      .in_item       (req_payload),
      .snr_thresh_sq (snr_thresh_sq_ff),
      .stage_out     (stage)
   );

   tpc_cluster #(
      .NUM_CHANNELS (NUM_CHANNELS)
   ) u_cluster (
      .clock           (clock),
      .reset           (reset),
      .advance         (advance),
      .stage_in        (stage),
      .max_gap_samples (max_gap_samples_ff),
      .emit            (emit),
      .event_out       (event_item)
   );

   // result register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (advance) begin
         if (emit) begin
            rsp_valid_ff <= 1'b1;
         end else if (!rsp_stall) begin
            rsp_valid_ff <= 1'b0;
         end
      end
      if (advance && emit) begin
         rsp_payload_ff <= event_item;
      end
   end

   assign rsp_valid   = rsp_valid_ff;
   assign rsp_payload = rsp_payload_ff;

endmodule

### hw/rtl/tpc_checker.sv
`timescale 1ns / 1ps

module tpc_checker (
   input logic                     clock,
   input logic                     reset,
   input logic                     req_valid,
   input logic                     req_stall,
   input tpc_pkg::req_payload_type req_payload,
   input logic                     rsp_valid,
   input logic                     rsp_stall,
   input tpc_pkg::rsp_payload_type rsp_payload
);

   // a blocked item stays and holds its value
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_payload))
      else $error("result item dropped or changed while stalled");

   // input back-pressure only comes from a blocked result
   assert property (@(posedge clock) disable iff (reset)
      req_stall |-> rsp_valid && rsp_stall)
      else $error("input stalled while result side is free");

   // reset empties the result register
   assert property (@(posedge clock)
      $past(reset) |-> !rsp_valid)
      else $error("result valid right after reset");

   // a result must pass the input and second-stage registers after reset before it can appear
   assert property (@(posedge clock)
      $rose(rsp_valid) |-> !$past(reset, 1) && !$past(reset, 2))
      else $error("result item too soon after reset");

   // a stalled input item stays and holds its value
   assert property (@(posedge clock) disable iff (reset)
      req_valid && req_stall |=> req_valid && $stable(req_payload))
      else $error("stalled input item changed");

endmodule

bind per_channel_trigger_peak_clustering tpc_checker u_checker (
   .clock       (clock),
   .reset       (reset),
   .req_valid   (req_valid),
   .req_stall   (req_stall),
   .req_payload (req_payload),
   .rsp_valid   (rsp_valid),
   .rsp_stall   (rsp_stall),
   .rsp_payload (rsp_payload)
);
